>>> sv/shp_pkg.sv
// Shared constants, types and helper function for the 3x3 sharpen stream.
// No dependencies; every other file but shp_ram imports this package.
package shp_pkg;

   // Line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = 17;
   localparam int EMIT_W    = 27;

   // Configuration register fields and indexes
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CFG_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd1024;
   localparam logic [CFG_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 16'd768;

   // Queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int PIX_W = 32;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic [7:0]         alpha;
      logic [8:0][23:0]   rgb;
      logic               interior;
      logic               frame_end;
   } queue_entry_type;

   typedef struct packed {
      logic            push;
      queue_entry_type entry;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              not_empty;
      queue_entry_type   head;
   } queue_status_type;

   // Nine times centre minus the eight neighbors, clamped to 0..255
   function automatic logic [7:0] sharpen_chan(input logic [8:0][7:0] v);
      logic [11:0]        pos;
      logic [11:0]        neg;
      logic signed [12:0] diff;
      pos = {1'b0, v[4], 3'b000} + {4'b0000, v[4]};
      neg = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4) neg = neg + {4'b0000, v[k]};
      end
      diff = $signed({1'b0, pos}) - $signed({1'b0, neg});
      if (diff < 0) return 8'd0;
      if (diff > 13'sd255) return 8'd255;
      return diff[7:0];
   endfunction

endpackage

>>> sv/shp_if.sv
// Valid/ready channel interfaces: pixel requests, results and register writes.
// Depends on shp_pkg.
interface shp_req_if;
   import shp_pkg::*;
   logic      valid;
   logic      ready;
   logic      mode;
   pixel_type pixel_word;
   modport source (output valid, mode, pixel_word, input ready);
   modport sink   (input valid, mode, pixel_word, output ready);
endinterface

interface shp_rsp_if;
   import shp_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type result_word;
   logic      frame_end;
   modport source (output valid, result_word, frame_end, input ready);
   modport sink   (input valid, result_word, frame_end, output ready);
endinterface

interface shp_csr_if;
   import shp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/shp_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read returns the old data on a same-address write. No dependencies.
module shp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

>>> sv/shp_front.sv
// Front end: registers, position counters, line stores and the 3x3 window.
// Classifies each transaction and pushes due results. Depends on shp_pkg, shp_ram.
module shp_front (
   input  logic                     clock,
   input  logic                     reset,
   shp_req_if.sink                  req_chan,
   shp_csr_if.sink                  csr_chan,
   input  shp_pkg::queue_status_type q_status,
   output shp_pkg::push_type        push_out
);
   import shp_pkg::*;

   logic [CFG_WIDTH_W-1:0]  frame_width_ff;
   logic [CFG_HEIGHT_W-1:0] frame_height_ff;
   logic [EMIT_W-1:0]       wh_ff;
   logic                    csr_settle_ff;
   logic [COL_W-1:0]        col_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [EMIT_W-1:0]       emit_ff;
   logic [8:0][PIX_W-1:0]   window_ff, window_in;

   logic                    s1_valid_ff, s1_due_ff, s1_interior_ff, s1_last_ff;
   logic [COL_W-1:0]        s1_col_ff;
   pixel_type               s1_px_ff;
   logic                    fwd_hit_ff;
   pixel_type               fwd_data_ff;

   logic [COL_W:0]          w_eff;
   logic [CFG_HEIGHT_W-1:0] h_eff;
   logic                    wrap, complete, ignore, accept, take, end_row, due;
   logic                    interior, last;
   logic [COL_W-1:0]        col_cur;
   logic [COL_W:0]          col_next;
   logic [ROW_W-1:0]        row_cur;
   pixel_type               px, older_q, newer_q, older_eff;

   // Configuration writes; the frame size product is registered from the updated fields
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         wh_ff           <= EMIT_W'(RST_FRAME_WIDTH) * EMIT_W'(RST_FRAME_HEIGHT);
         csr_settle_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_chan.data[CFG_WIDTH_W-1:0];
               REG_FRAME_HEIGHT: frame_height_ff <= csr_chan.data;
               default: ;
            endcase
         end
         wh_ff         <= EMIT_W'(w_eff) * EMIT_W'(h_eff);
         csr_settle_ff <= csr_chan.valid;
      end
   end

   // Clamp the frame size
   always_comb begin
      if (frame_width_ff == '0) w_eff = (COL_W+1)'(1);
      else if (32'(frame_width_ff) > MAX_WIDTH) w_eff = (COL_W+1)'(MAX_WIDTH);
      else w_eff = (COL_W+1)'(frame_width_ff);
      h_eff = (frame_height_ff == '0) ? CFG_HEIGHT_W'(1) : frame_height_ff;
   end

   // Classify the incoming transaction
   always_comb begin
      wrap     = {1'b0, col_ff} >= w_eff;
      col_cur  = wrap ? '0 : col_ff;
      row_cur  = wrap ? row_ff + 1'b1 : row_ff;
      complete = row_cur >= ROW_W'(h_eff);
      ignore   = !complete && req_chan.mode;
      accept   = req_chan.valid && req_chan.ready;
      take     = accept && !ignore;
      px       = complete ? '0 : req_chan.pixel_word;
      col_next = {1'b0, col_cur} + 1'b1;
      end_row  = col_next >= w_eff;
      due      = (row_cur >= ROW_W'(2)) || (row_cur == ROW_W'(1) && col_cur != '0);
      interior = (col_cur >= COL_W'(2)) && (row_cur >= ROW_W'(2))
                 && (row_cur < ROW_W'(h_eff));
      last     = due && ((emit_ff + 1'b1) >= wh_ff);
   end

   // Leave room in the queue for the transaction in flight; hold off while
   // the frame size product settles after a register write
   assign req_chan.ready = ((QCNT_W'(q_status.count) + QCNT_W'(s1_valid_ff))
                            < QCNT_W'(QUEUE_DEPTH)) && !csr_settle_ff;

   // Advance the position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         emit_ff <= '0;
      end else if (accept) begin
         if (ignore) begin
            col_ff <= col_cur;
            row_ff <= row_cur;
         end else if (last) begin
            col_ff  <= '0;
            row_ff  <= '0;
            emit_ff <= '0;
         end else begin
            col_ff  <= end_row ? '0 : col_next[COL_W-1:0];
            row_ff  <= end_row ? row_cur + 1'b1 : row_cur;
            if (due) emit_ff <= emit_ff + 1'b1;
         end
      end
   end

   // Hold the transaction for the line store read
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= take;
      s1_col_ff      <= col_cur;
      s1_px_ff       <= px;
      s1_due_ff      <= due;
      s1_interior_ff <= interior;
      s1_last_ff     <= last;
      fwd_hit_ff     <= s1_valid_ff && (s1_col_ff == col_cur);
      fwd_data_ff    <= newer_q;
   end

   // Line stores: newer row written when an accepted transaction is taken, older row in the cycle after
   shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
      .clock(clock), .we(take), .waddr(col_cur), .wdata(px),
      .raddr(col_cur), .rdata(newer_q)
   );
   shp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
      .clock(clock), .we(s1_valid_ff), .waddr(s1_col_ff), .wdata(newer_q),
      .raddr(col_cur), .rdata(older_q)
   );

   // Shift the window and insert the new column
   always_comb begin
      older_eff = fwd_hit_ff ? fwd_data_ff : older_q;
      window_in = window_ff;
      for (int r = 0; r < 3; r++) begin
         window_in[r*3+0] = window_ff[r*3+1];
         window_in[r*3+1] = window_ff[r*3+2];
      end
      window_in[2] = older_eff;
      window_in[5] = newer_q;
      window_in[8] = s1_px_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)            window_ff <= '0;
      else if (s1_valid_ff) window_ff <= window_in;
   end

   // Push due results to the queue
   always_comb begin
      push_out.push               = s1_valid_ff && s1_due_ff;
      push_out.entry.alpha        = window_in[4][31:24];
      for (int k = 0; k < 9; k++) push_out.entry.rgb[k] = window_in[k][23:0];
      push_out.entry.interior     = s1_interior_ff;
      push_out.entry.frame_end    = s1_last_ff;
   end
endmodule

>>> sv/shp_queue.sv
// Short queue between front and back ends.
// Depends on shp_pkg.
module shp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  shp_pkg::push_type        push_in,
   input  logic                     pop,
   output shp_pkg::queue_status_type q_status
);
   import shp_pkg::*;

   queue_entry_type   entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] head_ff, tail_ff;
   logic [QCNT_W-1:0] count_ff;

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push_in.push) entry_ff[tail_ff] <= push_in.entry;
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push_in.push) tail_ff <= tail_ff + 1'b1;
         if (pop)          head_ff <= head_ff + 1'b1;
         count_ff <= count_ff + QCNT_W'(push_in.push) - QCNT_W'(pop);
      end
   end

   assign q_status.count     = count_ff;
   assign q_status.not_empty = count_ff != '0;
   assign q_status.head      = entry_ff[head_ff];
endmodule

>>> sv/shp_back.sv
// Back end: per-channel sharpen arithmetic and the result output register.
// Depends on shp_pkg.
module shp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  shp_pkg::queue_status_type q_status,
   output logic                     pop,
   shp_rsp_if.source                rsp_chan
);
   import shp_pkg::*;

   logic      rsp_valid_ff;
   pixel_type result_ff, result_in;
   logic      frame_end_ff;
   logic [8:0][7:0] vr, vg, vb;

   // Sharpen interior pixels, copy border pixels
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         vr[k] = q_status.head.rgb[k][23:16];
         vg[k] = q_status.head.rgb[k][15:8];
         vb[k] = q_status.head.rgb[k][7:0];
      end
      if (q_status.head.interior)
         result_in = {q_status.head.alpha, sharpen_chan(vr), sharpen_chan(vg),
                      sharpen_chan(vb)};
      else
         result_in = {q_status.head.alpha, q_status.head.rgb[4]};
   end

   // Load the output register when it is empty or being taken
   assign pop = q_status.not_empty && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset)                      rsp_valid_ff <= 1'b0;
      else if (pop)                   rsp_valid_ff <= 1'b1;
      else if (rsp_chan.ready)        rsp_valid_ff <= 1'b0;
      if (pop) begin
         result_ff    <= result_in;
         frame_end_ff <= q_status.head.frame_end;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_word = result_ff;
   assign rsp_chan.frame_end   = frame_end_ff;
endmodule

>>> sv/sharpen_3x3_stream.sv
// 3x3 sharpen over a raster ARGB stream. Throughput: one transaction per cycle while
// the queue has room, with ready held low in the cycle after each register write.
// A result is offered after the transaction that completes its window is accepted
// (width+1 pixels after its own pixel); the line store read stage, the queue and the output register lie between.
// Reset (synchronous, active high) clears counters, window and queue and loads
// width 1024, height 768; line stores are not cleared, and their contents reach results only after being written.
module sharpen_3x3_stream (
   input  logic      clock,
   input  logic      reset,
   shp_req_if.sink   req_chan,
   shp_rsp_if.source rsp_chan,
   shp_csr_if.sink   csr_chan
);
   import shp_pkg::*;

   push_type         push;
   queue_status_type q_status;
   logic             pop;

   shp_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .csr_chan(csr_chan),
      .q_status(q_status), .push_out(push)
   );

   shp_queue u_queue (
      .clock(clock), .reset(reset), .push_in(push), .pop(pop), .q_status(q_status)
   );

   shp_back u_back (
      .clock(clock), .reset(reset), .q_status(q_status), .pop(pop),
      .rsp_chan(rsp_chan)
   );
endmodule

>>> sv/shp_checker.sv
// Port-level checks for sharpen_3x3_stream, attached by bind.
// Depends on shp_pkg.
module shp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input shp_pkg::pixel_type rsp_word,
   input logic              rsp_frame_end
);
   import shp_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word)
      && $stable(rsp_frame_end))
      else $error("stalled result changed");

   // No result right after reset
   a_rst_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A new result follows an earlier accepted transaction
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("result without a cause");
endmodule

bind sharpen_3x3_stream shp_checker u_shp_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_word(rsp_chan.result_word), .rsp_frame_end(rsp_chan.frame_end)
);

>>> dv/shp_tb_if.sv
// Testbench-side notes: the channel interfaces come from sv/shp_if.sv.
// This file holds the small helper package of stimulus constants; depends on shp_pkg.
package shp_tb_pkg;
   import shp_pkg::*;
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;
endpackage

>>> dv/shp_checker.sv
// Checker for sharpen_3x3_stream: watches request, result and register channels,
// predicts each result and compares it in order. Depends on shp_pkg, shp_tb_pkg, shp_if.
module shp_tb_checker
   import shp_pkg::*;
   import shp_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   shp_req_if.sink    req_mon,
   shp_rsp_if.sink    rsp_mon,
   shp_csr_if.sink    csr_mon,
   output int         fail_count,
   output int         pending_count
);
   typedef struct {
      pixel_type word;
      logic      last;
   } sharp_result_type;

   pixel_type     older_row [MAX_WIDTH];
   pixel_type     newer_row [MAX_WIDTH];
   pixel_type     win [9];
   int unsigned   col_pos, row_pos, emit_total;
   logic [CFG_WIDTH_W-1:0]  cfg_width;
   logic [CFG_HEIGHT_W-1:0] cfg_height;
   sharp_result_type expected_pixels [$];

   // 9*centre minus neighbors for one channel, clamped
   function automatic logic [7:0] sharpen_byte(int sh);
      int acc;
      int v;
      acc = 0;
      for (int k = 0; k < 9; k++) begin
         v = (win[k] >> sh) & 8'hFF;
         acc += (k == 4) ? 9 * v : -v;
      end
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[7:0];
   endfunction

   // Advance the predictor by one accepted request
   task automatic predict_pixel(logic mode, pixel_type word);
      int unsigned w, h, col, row, cy, cx;
      pixel_type px, ctr, res;
      logic complete, due, interior;
      sharp_result_type r;
      w = 32'(cfg_width);
      h = 32'(cfg_height);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < 1) h = 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      complete = row_pos >= h;
      if (!complete && mode == MODE_FLUSH) return;
      px = complete ? '0 : word;
      col = col_pos;
      row = row_pos;
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = older_row[col];
      win[5] = newer_row[col];
      win[8] = px;
      older_row[col] = newer_row[col];
      newer_row[col] = px;
      due = (row >= 2) || (row == 1 && col >= 1);
      col_pos = col + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = row + 1;
      end
      if (!due) return;
      if (col == 0) begin
         cy = row - 2;
         cx = w - 1;
      end else begin
         cy = row - 1;
         cx = col - 1;
      end
      ctr = win[4];
      interior = cy >= 1 && cy + 2 <= h && cx >= 1 && cx + 2 <= w;
      res = interior ? {ctr[31:24], sharpen_byte(16), sharpen_byte(8), sharpen_byte(0)}
                     : ctr;
      r.word = res;
      emit_total++;
      if (64'(emit_total) >= 64'(w) * 64'(h)) begin
         r.last = 1'b1;
         emit_total = 0;
         col_pos = 0;
         row_pos = 0;
      end else begin
         r.last = 1'b0;
      end
      expected_pixels.push_back(r);
   endtask

   // Sample all channels at the clock edge
   always @(posedge clock) begin
      sharp_result_type e;
      if (reset) begin
         foreach (win[k]) win[k] = '0;
         col_pos = 0;
         row_pos = 0;
         emit_total = 0;
         cfg_width = RST_FRAME_WIDTH;
         cfg_height = RST_FRAME_HEIGHT;
         expected_pixels.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_FRAME_WIDTH) cfg_width = csr_mon.data[CFG_WIDTH_W-1:0];
            else if (csr_mon.index == REG_FRAME_HEIGHT) cfg_height = csr_mon.data;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result_word %h", rsp_mon.result_word);
               fail_count++;
            end else begin
               e = expected_pixels.pop_front();
               if (rsp_mon.result_word !== e.word) begin
                  $error("result_word expected %h actual %h", e.word, rsp_mon.result_word);
                  fail_count++;
               end
               if (rsp_mon.frame_end !== e.last) begin
                  $error("frame_end expected %b actual %b", e.last, rsp_mon.frame_end);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) predict_pixel(req_mon.mode, req_mon.pixel_word);
         pending_count = expected_pixels.size();
      end
   end
endmodule

>>> dv/tb_sharpen_3x3_stream.sv
// Top of the sharpen_3x3_stream testbench: clock, reset, stimulus and verdict.
// Depends on shp_pkg, shp_tb_pkg, shp_if, shp_checker and the block.
module tb_sharpen_3x3_stream;
   import shp_pkg::*;
   import shp_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_off_len = 0;
   int   hold_off_count = 0;
   longint cycle_count = 0;
   int unsigned cur_w = 32'(RST_FRAME_WIDTH), cur_h = 32'(RST_FRAME_HEIGHT);

   shp_req_if req_chan ();
   shp_rsp_if rsp_chan ();
   shp_csr_if csr_chan ();

   sharpen_3x3_stream u_top (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source), .csr_chan(csr_chan.sink)
   );

   shp_tb_checker u_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_chan), .rsp_mon(rsp_chan), .csr_mon(csr_chan),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus a long counted hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_count < hold_off_len) begin
         rsp_chan.ready <= 1'b0;
         hold_off_count <= hold_off_count + 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("** sharpen_3x3_stream: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   // Offer one transaction, with random idle cycles first
   task automatic send_item(logic mode, pixel_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= mode;
      req_chan.pixel_word <= word;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   function automatic pixel_type rand_pixel();
      unique case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return {8'($urandom), 24'hFFFFFF};
         3: return {$urandom} & 32'hFF00FF00;
         default: return $urandom;
      endcase
   endfunction

   // Wait until no result is outstanding, then let the pipeline settle
   task automatic drain_idle();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // One whole frame plus width+1 drain transactions; a few noise items at random when noisy
   task automatic run_frame(int unsigned w, int unsigned h, bit noisy, bit flat);
      int unsigned ew, eh;
      ew = (w < 1) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
      eh = (h < 1) ? 1 : h;
      if (w != cur_w) write_reg(REG_FRAME_WIDTH, 16'(w));
      if (h != cur_h) write_reg(REG_FRAME_HEIGHT, 16'(h));
      cur_w = w;
      cur_h = h;
      for (int unsigned i = 0; i < ew * eh; i++) begin
         if (noisy && $urandom_range(19) == 0) send_item(MODE_FLUSH, $urandom);
         send_item(MODE_PIXEL, flat ? 32'h80FF00FF : rand_pixel());
      end
      for (int unsigned i = 0; i <= ew; i++) begin
         send_item($urandom_range(3) == 0 ? MODE_PIXEL : MODE_FLUSH, $urandom);
      end
      drain_idle();
   endtask

   initial begin
      int phase;
      int unsigned w, h;
      req_chan.valid = 1'b0;
      req_chan.mode = MODE_PIXEL;
      req_chan.pixel_word = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = REG_FRAME_WIDTH;
      csr_chan.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: small and degenerate shapes, extreme pixels, out-of-range registers
      run_frame(3, 3, 0, 0);
      run_frame(1, 1, 0, 0);
      run_frame(2, 4, 1, 0);
      run_frame(4, 1, 0, 0);
      run_frame(0, 0, 0, 1);
      run_frame(5, 3, 0, 1);
      // Long receiver hold-off while the sender keeps offering
      hold_off_len = 200;
      run_frame(6, 5, 0, 0);
      // Wider row, few lines
      run_frame(48, 3, 0, 0);
      // Random part through the idle phases
      for (int n = 0; n < 24; n++) begin
         phase = n % 4;
         send_idle_pct = (phase == 1) ? 50 : (phase == 3 ? 31 : 0);
         recv_stall_pct = (phase == 2) ? 50 : (phase == 3 ? 31 : 0);
         w = $urandom_range(1, 9);
         h = $urandom_range(1, 6);
         if (n == 5) h = 65535 & 16'h0003;
         run_frame(w, h, 1, 0);
      end
      write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
      write_reg(REG_FRAME_WIDTH, 16'd3);
      cur_w = 3;
      cur_h = 65535;
      repeat (40) send_item(MODE_PIXEL, rand_pixel());
      drain_idle();
      // Finishing that tall frame is impractical; shrink the height mid-frame
      write_reg(REG_FRAME_HEIGHT, 16'd14);
      cur_h = 14;
      repeat (2) send_item(MODE_PIXEL, rand_pixel());
      repeat (5) send_item(MODE_FLUSH, '0);
      drain_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("** sharpen_3x3_stream: PASSED **");
      end else begin
         $display("** sharpen_3x3_stream: FAILED **");
      end
      $finish;
   end
endmodule
